### rtl/core/asde_pkg.sv
// shared types, constants and helpers of the string directive encoder
// no dependencies; imported by the top level, the parser and the testbench

package asde_pkg;

   localparam int BufDepthDefault = 62;
   localparam int CountW          = 7;
   localparam int IdxW            = 6;
   localparam int ErrW            = 3;
   localparam int ModeW           = 3;

   // error codes
   localparam logic [ErrW-1:0] ErrNone     = 3'd0;
   localparam logic [ErrW-1:0] ErrMismatch = 3'd1;
   localparam logic [ErrW-1:0] ErrOperand  = 3'd2;
   localparam logic [ErrW-1:0] ErrMode     = 3'd3;
   localparam logic [ErrW-1:0] ErrOverflow = 3'd4;

   // directive modes
   localparam logic [ModeW-1:0] ModeAsc  = 3'd0;
   localparam logic [ModeW-1:0] ModeStr  = 3'd1;
   localparam logic [ModeW-1:0] ModeStrl = 3'd2;
   localparam logic [ModeW-1:0] ModeRev  = 3'd3;
   localparam logic [ModeW-1:0] ModeFls  = 3'd4;
   localparam logic [ModeW-1:0] ModeInv  = 3'd5;
   localparam logic [ModeW-1:0] ModeDci  = 3'd6;

   localparam logic [7:0] DelimSplit = 8'h27;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] MaskLimit  = 8'h60;
   localparam logic [7:0] FlashBit   = 8'h40;

   // csr register index
   localparam logic RegEmitEnable = 1'b0;

   // run status handed from the character parser to the emit sequencer
   typedef struct packed {
      logic [CountW-1:0] fill;
      logic              text_open;
      logic              nibble;
      logic              first_high;
      logic [IdxW-1:0]   last_text;
      logic              mismatch;
      logic              overflow;
   } status_type;

   // hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

### rtl/core/assembler_string_directive_encoder_unit.sv
// top level of the string directive encoder: csr, emit sequencer, output register
// depends on asde_pkg, asde_ram and asde_parse
// requests other than a last one are taken one per cycle while idle; a last request holds
// off the next until its run is out (plan, then ram read and output load per result, with
// one result per byte plus length prefix, or a single one when none go out); stalls add to it
// reset: synchronous, clears control and csr (emit_enable 1); text buffer left as is

module assembler_string_directive_encoder_unit
   import asde_pkg::*;
#(
   parameter int BufDepth = BufDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_character,
   input  logic              req_has_char,
   input  logic [ModeW-1:0]  req_mode,
   input  logic              req_last,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_byte_valid,
   output logic [CountW-1:0] rsp_byte_count,
   output logic [ErrW-1:0]   rsp_error_code,
   output logic              rsp_end_of_run,
   // csr port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AddrW = BufDepth > 1 ? $clog2(BufDepth) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PLAN,
      S_READ,
      S_PUT
   } state_type;

   // sequencer state and registered outputs
   state_type         state_ff, state_in;
   logic              emit_enable_ff, emit_enable_in;
   logic [ModeW-1:0]  mode_ff, mode_in;
   logic [CountW-1:0] idx_ff, idx_in;
   logic [CountW-1:0] total_ff, total_in;
   logic [1:0]        prefix_ff, prefix_in;
   logic              rev_ff, rev_in;
   logic              mask_ff, mask_in;
   logic              flash_ff, flash_in;
   logic              dci_ff, dci_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [ErrW-1:0]   err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_bvalid_ff, rsp_bvalid_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic [ErrW-1:0]   rsp_err_ff, rsp_err_in;
   logic              rsp_eor_ff, rsp_eor_in;

   status_type        status;
   logic              accept;
   logic              run_clear;
   logic              csr_write;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [7:0]        wr_data;
   logic [AddrW-1:0]  rd_addr;
   logic [7:0]        rd_data;

   // plan decode
   logic [1:0]        plan_prefix;
   logic              plan_rev;
   logic              plan_mask;
   logic              plan_flash;
   logic              plan_dci;
   logic              plan_bad_mode;

   // walk of the buffer
   logic [CountW-1:0] data_idx;
   logic [CountW-1:0] buf_idx;
   logic              out_free;
   logic              is_final;
   logic [7:0]        low7;
   logic [7:0]        put_byte;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // csr: a single register at word 0; writes elsewhere are dropped
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == RegEmitEnable);
   assign prdata    = (paddr[2] == RegEmitEnable) ? {31'd0, emit_enable_ff} : 32'd0;

   asde_parse #(
      .BufDepth (BufDepth)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (accept && req_has_char),
      .character (req_character),
      .run_clear (run_clear),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .status    (status)
   );

   asde_ram #(
      .Width (8),
      .Depth (BufDepth)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // mode decode, taken in the plan cycle
   always_comb begin
      plan_prefix   = 2'd0;
      plan_rev      = 1'b0;
      plan_mask     = 1'b0;
      plan_flash    = 1'b0;
      plan_dci      = 1'b0;
      plan_bad_mode = 1'b0;
      unique case (mode_ff)
         ModeAsc:  plan_prefix = 2'd0;
         ModeStr:  plan_prefix = 2'd1;
         ModeStrl: plan_prefix = 2'd2;
         ModeRev:  plan_rev    = 1'b1;
         ModeFls: begin
            plan_mask  = 1'b1;
            plan_flash = 1'b1;
         end
         ModeInv:  plan_mask   = 1'b1;
         ModeDci:  plan_dci    = 1'b1;
         default:  plan_bad_mode = 1'b1;
      endcase
   end

   // result index past the length prefix, and its place in the buffer
   assign data_idx = idx_ff - CountW'(prefix_ff);
   assign buf_idx  = rev_ff ? (status.fill - CountW'(1) - data_idx) : data_idx;
   assign rd_addr  = buf_idx[AddrW-1:0];

   // byte transform of the current buffer read
   assign low7 = {1'b0, rd_data[6:0]};
   always_comb begin
      put_byte = rd_data;
      if (idx_ff < CountW'(prefix_ff)) begin
         // length prefix: low byte of the fill count, then a zero high byte
         put_byte = (idx_ff == CountW'(0)) ? 8'(status.fill) : 8'd0;
      end else begin
         if (mask_ff) begin
            if (low7 < MaskLimit) begin
               put_byte = {2'b00, low7[5:0]} | (flash_ff ? FlashBit : 8'd0);
            end else begin
               put_byte = low7;
            end
         end
         if (dci_ff && (data_idx[IdxW-1:0] == status.last_text)) begin
            put_byte[7] = status.first_high;
         end
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_final  = (total_ff == CountW'(0)) || (idx_ff + CountW'(1) == total_ff);
   assign run_clear = (state_ff == S_PUT) && out_free && is_final;

   always_comb begin
      state_in       = state_ff;
      emit_enable_in = emit_enable_ff;
      mode_in        = mode_ff;
      idx_in         = idx_ff;
      total_in       = total_ff;
      prefix_in      = prefix_ff;
      rev_in         = rev_ff;
      mask_in        = mask_ff;
      flash_in       = flash_ff;
      dci_in         = dci_ff;
      count_in       = count_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_bvalid_in  = rsp_bvalid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_eor_in     = rsp_eor_ff;

      if (csr_write) begin
         emit_enable_in = pwdata[0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               if (req_last) begin
                  state_in = S_PLAN;
               end
            end
         end
         S_PLAN: begin
            // parser state now includes the last character
            idx_in    = '0;
            prefix_in = plan_prefix;
            rev_in    = plan_rev;
            mask_in   = plan_mask;
            flash_in  = plan_flash;
            dci_in    = plan_dci;
            priority if (status.overflow) begin
               err_in   = ErrOverflow;
               count_in = '0;
               total_in = '0;
            end else if (status.text_open || status.nibble) begin
               err_in   = ErrOperand;
               count_in = '0;
               total_in = '0;
            end else begin
               // unknown mode still emits the bytes unchanged, count zero
               count_in = plan_bad_mode ? CountW'(0)
                                        : status.fill + CountW'(plan_prefix);
               err_in   = plan_bad_mode ? ErrMode
                        : (status.mismatch ? ErrMismatch : ErrNone);
               total_in = emit_enable_ff ? status.fill + CountW'(plan_prefix)
                                         : CountW'(0);
            end
            state_in = S_READ;
         end
         S_READ: begin
            // ram address settles here, data is ready in the next cycle
            state_in = S_PUT;
         end
         S_PUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bvalid_in = (total_ff != CountW'(0));
               rsp_data_in   = (total_ff != CountW'(0)) ? put_byte : 8'd0;
               rsp_count_in  = is_final ? count_ff : CountW'(0);
               rsp_err_in    = is_final ? err_ff : ErrNone;
               rsp_eor_in    = is_final;
               if (is_final) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CountW'(1);
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         emit_enable_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         emit_enable_ff <= emit_enable_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      total_ff      <= total_in;
      prefix_ff     <= prefix_in;
      rev_ff        <= rev_in;
      mask_ff       <= mask_in;
      flash_ff      <= flash_in;
      dci_ff        <= dci_in;
      count_ff      <= count_in;
      err_ff        <= err_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_eor_ff    <= rsp_eor_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_end_of_run = rsp_eor_ff;

endmodule

### rtl/core/asde_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing

module asde_ram #(
   parameter int Width = 8,
   parameter int Depth = 62
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                       wr_data,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                       rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/asde_parse.sv
// operand character parser: delimiters, hex pairs, buffer write port
// depends on asde_pkg

module asde_parse
   import asde_pkg::*;
#(
   parameter int BufDepth = BufDepthDefault
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         take,
   input  logic [7:0]                                   character,
   input  logic                                         run_clear,
   output logic                                         wr_en,
   output logic [(BufDepth > 1 ? $clog2(BufDepth) : 1)-1:0] wr_addr,
   output logic [7:0]                                   wr_data,
   output status_type                                   status
);

   localparam int AddrW = BufDepth > 1 ? $clog2(BufDepth) : 1;

   logic [CountW-1:0] fill_ff, fill_in;
   logic [7:0]        open_ff, open_in;
   logic [7:0]        first_ff, first_in;
   logic              nibble_ff, nibble_in;
   logic [3:0]        partial_ff, partial_in;
   logic [IdxW-1:0]   last_text_ff, last_text_in;
   logic              mismatch_ff, mismatch_in;
   logic              overflow_ff, overflow_in;

   logic [4:0] hex;
   logic       store;
   logic       store_text;
   logic [7:0] store_byte;
   logic       full;

   assign hex  = hex_value(character);
   assign full = (fill_ff >= CountW'(BufDepth));

   always_comb begin
      fill_in      = fill_ff;
      open_in      = open_ff;
      first_in     = first_ff;
      nibble_in    = nibble_ff;
      partial_in   = partial_ff;
      last_text_in = last_text_ff;
      mismatch_in  = mismatch_ff;
      overflow_in  = overflow_ff;
      store        = 1'b0;
      store_text   = 1'b0;
      store_byte   = 8'd0;

      if (take) begin
         if (open_ff != 8'd0) begin
            if (character == open_ff) begin
               open_in = 8'd0;
            end else begin
               store      = 1'b1;
               store_text = 1'b1;
               store_byte = (open_ff >= DelimSplit) ? {1'b0, character[6:0]}
                                                    : {1'b1, character[6:0]};
            end
         end else if (character == CharComma || character == CharSpace) begin
            open_in = open_ff;
         end else if (!hex[4]) begin
            // a nul opens nothing but still counts for the mismatch check
            open_in = character;
            if (first_ff == 8'd0) begin
               first_in = character;
            end else if (character != first_ff) begin
               mismatch_in = 1'b1;
            end
         end else if (!nibble_ff) begin
            partial_in = hex[3:0];
            nibble_in  = 1'b1;
         end else begin
            store      = 1'b1;
            store_byte = {partial_ff, hex[3:0]};
            partial_in = 4'd0;
            nibble_in  = 1'b0;
         end
      end

      if (store) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            fill_in = fill_ff + CountW'(1);
            if (store_text) begin
               last_text_in = fill_ff[IdxW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || run_clear) begin
         fill_ff      <= '0;
         open_ff      <= '0;
         first_ff     <= '0;
         nibble_ff    <= 1'b0;
         partial_ff   <= '0;
         last_text_ff <= '0;
         mismatch_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         open_ff      <= open_in;
         first_ff     <= first_in;
         nibble_ff    <= nibble_in;
         partial_ff   <= partial_in;
         last_text_ff <= last_text_in;
         mismatch_ff  <= mismatch_in;
         overflow_ff  <= overflow_in;
      end
   end

   assign wr_en   = store && !full;
   assign wr_addr = fill_ff[AddrW-1:0];
   assign wr_data = store_byte;

   assign status.fill       = fill_ff;
   assign status.text_open  = (open_ff != 8'd0);
   assign status.nibble     = nibble_ff;
   assign status.first_high = (first_ff >= DelimSplit);
   assign status.last_text  = last_text_ff;
   assign status.mismatch   = mismatch_ff;
   assign status.overflow   = overflow_ff;

endmodule

### dv/tb_assembler_string_directive_encoder_unit.sv
// testbench of the string directive encoder: random and directed operands,
// a self-checking predictor and a response scoreboard
// depends on asde_pkg and assembler_string_directive_encoder_unit

module tb_assembler_string_directive_encoder_unit
   import asde_pkg::*;
();

   // mode value the block does not know
   localparam logic [ModeW-1:0] ModeUnknown = 3'd7;
   // byte address of the emit enable register
   localparam logic [2:0] AddrEmitEnable = 3'(4 * int'(RegEmitEnable));
   // cycles of the long receiver hold-off
   localparam int HoldCycles = 300;
   // random requests after the directed and structured phases
   localparam int RandomItems = 30;

   // one expected response
   typedef struct packed {
      logic [7:0]        data_byte;
      logic              byte_valid;
      logic [CountW-1:0] byte_count;
      logic [ErrW-1:0]   error_code;
      logic              end_of_run;
   } dir_byte_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_character;
   logic              req_has_char;
   logic [ModeW-1:0]  req_mode;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_data_byte;
   logic              rsp_byte_valid;
   logic [CountW-1:0] rsp_byte_count;
   logic [ErrW-1:0]   rsp_error_code;
   logic              rsp_end_of_run;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // predictor copy of the block state
   logic [7:0]        text_mem [0:BufDepthDefault-1];
   int                fill_level;
   logic [7:0]        open_delim;
   logic [7:0]        first_delim;
   logic              nibble_hi;
   logic [7:0]        partial_hi;
   logic [IdxW-1:0]   last_text_at;
   logic              mismatch_seen;
   logic              overflow_seen;
   logic              emit_on;

   dir_byte_type      expected_bytes [$];
   int                mismatches;
   int                items_sent;
   int                hold_req;     // bumped by the stimulus to ask for a long hold-off
   logic              no_idle;      // stretch with no gaps and no stalls

   assembler_string_directive_encoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_has_char   (req_has_char),
      .req_mode       (req_mode),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_byte_count (rsp_byte_count),
      .rsp_error_code (rsp_error_code),
      .rsp_end_of_run (rsp_end_of_run),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // hex value of a character, -1 when it is not a hex digit
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic void clear_operand();
      fill_level    = 0;
      open_delim    = 8'h00;
      first_delim   = 8'h00;
      nibble_hi     = 1'b0;
      partial_hi    = 8'h00;
      last_text_at  = '0;
      mismatch_seen = 1'b0;
      overflow_seen = 1'b0;
   endfunction

   // a byte that finds the buffer full is dropped and flags overflow
   function automatic void stash_byte(input logic [7:0] b, input logic is_text);
      if (fill_level >= BufDepthDefault) begin
         overflow_seen = 1'b1;
         return;
      end
      text_mem[fill_level] = b;
      if (is_text) last_text_at = IdxW'(fill_level);
      fill_level++;
   endfunction

   function automatic void take_character(input logic [7:0] c);
      int h;
      if (open_delim != 8'h00) begin
         if (c == open_delim) begin
            open_delim = 8'h00;
         end else if (open_delim >= DelimSplit) begin
            stash_byte({1'b0, c[6:0]}, 1'b1);
         end else begin
            stash_byte({1'b1, c[6:0]}, 1'b1);
         end
         return;
      end
      if (c == CharComma || c == CharSpace) return;
      h = hex_nibble(c);
      if (h < 0) begin
         // a nul opens nothing but still counts for the mismatch check
         open_delim = c;
         if (first_delim == 8'h00) first_delim = c;
         else if (c != first_delim) mismatch_seen = 1'b1;
         return;
      end
      if (!nibble_hi) begin
         partial_hi = {4'(h), 4'h0};
         nibble_hi  = 1'b1;
      end else begin
         stash_byte(partial_hi | 8'(h), 1'b0);
         partial_hi = 8'h00;
         nibble_hi  = 1'b0;
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      dir_byte_type r;
      r            = '0;
      r.data_byte  = b;
      r.byte_valid = 1'b1;
      expected_bytes.insert(expected_bytes.size(), r);
   endfunction

   // end of operand: transform by mode and queue the responses
   function automatic void close_operand(input logic [ModeW-1:0] mode);
      dir_byte_type    r;
      int              n0, prefix, i;
      logic            rev, dci, mask;
      logic [7:0]      orv, b;
      logic [ErrW-1:0] err;
      logic [CountW-1:0] cnt;
      n0     = expected_bytes.size();
      err    = ErrNone;
      cnt    = '0;
      prefix = 0;
      rev    = 1'b0;
      dci    = 1'b0;
      mask   = 1'b0;
      orv    = 8'h00;
      if (overflow_seen) begin
         err = ErrOverflow;
      end else if (open_delim != 8'h00 || nibble_hi) begin
         err = ErrOperand;
      end else begin
         case (mode)
            ModeAsc:  ;
            ModeStr:  prefix = 1;
            ModeStrl: prefix = 2;
            ModeRev:  rev = 1'b1;
            ModeFls: begin
               mask = 1'b1;
               orv  = FlashBit;
            end
            ModeInv:  mask = 1'b1;
            ModeDci:  dci = 1'b1;
            default:  err = ErrMode;
         endcase
         if (err != ErrMode) begin
            cnt = CountW'(fill_level + prefix);
            if (mismatch_seen) err = ErrMismatch;
         end
         if (emit_on) begin
            for (i = 0; i < prefix; i++) push_byte(i == 0 ? 8'(fill_level) : 8'h00);
            for (i = 0; i < fill_level; i++) begin
               b = rev ? text_mem[fill_level - 1 - i] : text_mem[i];
               if (mask) begin
                  b[7] = 1'b0;
                  if (b < MaskLimit) b = {2'b00, b[5:0]} | orv;
               end
               if (dci && i == int'(last_text_at)) b[7] = (first_delim >= DelimSplit);
               push_byte(b);
            end
         end
      end
      if (expected_bytes.size() == n0) begin
         r = '0;
         expected_bytes.insert(expected_bytes.size(), r);
      end
      r            = expected_bytes[$];
      r.byte_count = cnt;
      r.error_code = err;
      r.end_of_run = 1'b1;
      expected_bytes[expected_bytes.size() - 1] = r;
      clear_operand();
   endfunction

   // ---------------------------------------------------------------
   // response side: scoreboard and receiver stalls
   // ---------------------------------------------------------------

   task automatic show_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
   endtask

   // every accepted response is matched against the oldest expectation
   always @(posedge clock) begin : check_rsp
      dir_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: response expected none, got byte 0x%0h end %0b",
                     $time, rsp_data_byte, rsp_end_of_run);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data_byte !== want.data_byte)
               show_mismatch("data_byte", want.data_byte, rsp_data_byte);
            if (rsp_byte_valid !== want.byte_valid)
               show_mismatch("byte_valid", want.byte_valid, rsp_byte_valid);
            if (rsp_byte_count !== want.byte_count)
               show_mismatch("byte_count", want.byte_count, rsp_byte_count);
            if (rsp_error_code !== want.error_code)
               show_mismatch("error_code", want.error_code, rsp_error_code);
            if (rsp_end_of_run !== want.end_of_run)
               show_mismatch("end_of_run", want.end_of_run, rsp_end_of_run);
         end
      end
   end

   // receiver: short stall bursts, now and then a long one, and on request
   // a hold-off of HoldCycles counted here
   initial begin : rsp_stall_gen
      int seen, stall_left, n;
      rsp_stall  = 1'b0;
      seen       = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != seen) begin
            seen = hold_req;
            rsp_stall <= 1'b1;
            for (n = 0; n < HoldCycles; n++) @(posedge clock);
            stall_left = 0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 12)
               stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                        : $urandom_range(15, 40);
         end
      end
   end

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // sender gap after a request: mostly none or short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one request; valid stays high when no gap follows, so the caller
   // either sends again in the same step or lowers valid
   task automatic send_char(input logic [7:0] ch, input logic has,
                            input logic [ModeW-1:0] md, input logic lst);
      int gap;
      req_valid     <= 1'b1;
      req_character <= ch;
      req_has_char  <= has;
      req_mode      <= md;
      req_last      <= lst;
      do @(posedge clock); while (req_stall);
      if (has) take_character(ch);
      if (lst) close_operand(md);
      if (has || lst) items_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a whole operand; empty steps are sprinkled in and sometimes close it
   task automatic send_operand(input logic [7:0] op[$], input logic [ModeW-1:0] mode);
      int   i;
      logic tail_empty;
      tail_empty = ($urandom_range(0, 9) == 0);
      for (i = 0; i < op.size(); i++) begin
         if ($urandom_range(0, 19) == 0)
            send_char(8'($urandom), 1'b0, ModeW'($urandom), 1'b0);
         if (i == op.size() - 1)
            send_char(op[i], 1'b1, mode, !tail_empty);
         else
            send_char(op[i], 1'b1, ModeW'($urandom), 1'b0);
      end
      if (op.size() == 0 || tail_empty) send_char(8'($urandom), 1'b0, mode, 1'b1);
   endtask

   // drop valid, let every expected response arrive, then settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the emit enable register and read it back
   task automatic csr_write(input logic v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrEmitEnable;
      pwdata  <= {31'b0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      emit_on = v;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {31'b0, v}) show_mismatch("emit_enable readback", {31'b0, v}, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [7:0] random_delim();
      logic [7:0] d;
      case ($urandom_range(0, 5))
         0: d = "\"";
         1: d = "'";
         2: d = "/";
         3: d = "!";
         default: begin
            d = 8'($urandom_range(1, 255));
            while (hex_nibble(d) >= 0 || d == CharComma || d == CharSpace)
               d = 8'($urandom_range(1, 255));
         end
      endcase
      return d;
   endfunction

   // mostly well formed operands of text, hex pairs and separators;
   // some get noise characters inserted, some lose one character
   task automatic send_random_operand(input int max_text);
      logic [7:0] op[$];
      logic [7:0] d, c;
      string      hexset;
      int         shape, nseg, s, n, j;
      hexset = "0123456789abcdefABCDEF";
      shape  = $urandom_range(0, 99);
      d      = random_delim();
      nseg   = $urandom_range(1, 4);
      for (s = 0; s < nseg; s++) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               // a new delimiter now and then gives a mismatch
               if ($urandom_range(0, 4) == 0) d = random_delim();
               op.insert(op.size(), d);
               n = $urandom_range(0, max_text);
               for (j = 0; j < n; j++) begin
                  c = 8'($urandom_range(0, 255));
                  if (c == d) c = c ^ 8'h01;
                  op.insert(op.size(), c);
               end
               op.insert(op.size(), d);
            end
            2, 3: begin
               n = $urandom_range(1, 4);
               for (j = 0; j < 2 * n; j++)
                  op.insert(op.size(), hexset[$urandom_range(0, 21)]);
            end
            default: op.insert(op.size(), $urandom_range(0, 1) ? CharComma : CharSpace);
         endcase
      end
      if (shape < 12) begin
         n = $urandom_range(1, 3);
         for (j = 0; j < n; j++) op.insert($urandom_range(0, op.size()), 8'($urandom));
      end else if (shape < 20 && op.size() > 0) begin
         op.delete($urandom_range(0, op.size() - 1));
      end
      send_operand(op, ModeW'($urandom_range(0, 7)));
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // every mode and each special case on tiny operands
   task automatic test_directed();
      logic [7:0] op[$];
      op = '{"'", "A"};               // unterminated text
      send_operand(op, ModeStr);
      op = '{"F"};                    // odd nibble
      send_operand(op, ModeAsc);
      op = {};                        // empty operand
      send_operand(op, ModeRev);
      op = '{"\"", "z", "\""};        // low delimiter sets bit 7, two-byte prefix
      send_operand(op, ModeStrl);
      op = '{"'", 8'hFF, "'"};        // top character value, dci on the only text byte
      send_operand(op, ModeDci);
      op = '{"F", "F", " ", "0", "0"}; // hex with a space, flash masking
      send_operand(op, ModeFls);
      op = '{"0", "1", ",", "8", "0"}; // hex with a comma, reversed
      send_operand(op, ModeRev);
      op = '{"'", "a", "'", "/", "/"}; // second delimiter differs
      send_operand(op, ModeInv);
      op = '{"'", "q", "'", 8'h00};   // nul outside text, unknown mode
      send_operand(op, ModeUnknown);
      wait_idle();
   endtask

   // count only: just the closing response of each operand
   task automatic test_count_only();
      int k;
      csr_write(1'b0);
      for (k = 0; k < 3; k++) send_random_operand(8);
      wait_idle();
      csr_write(1'b1);
   endtask

   // one byte past the buffer, then a buffer filled exactly
   task automatic test_overflow();
      logic [7:0] op[$];
      logic [7:0] c;
      int         j;
      op.insert(op.size(), "'");
      for (j = 0; j < BufDepthDefault + 1; j++) begin
         c = 8'($urandom);
         if (c == "'") c = 8'h00;
         op.insert(op.size(), c);
      end
      op.insert(op.size(), "'");
      send_operand(op, ModeAsc);
      op = {};
      op.insert(op.size(), "\"");
      for (j = 0; j < BufDepthDefault; j++) begin
         c = 8'($urandom);
         if (c == "\"") c = c ^ 8'h01;
         op.insert(op.size(), c);
      end
      op.insert(op.size(), "\"");
      send_operand(op, ModeStrl);
      wait_idle();
   endtask

   // receiver holds off long while the sender keeps going, so the block
   // backs up and stalls its request side
   task automatic test_backpressure();
      int k;
      hold_req++;
      for (k = 0; k < 2; k++) send_random_operand(20);
      wait_idle();
   endtask

   // sender stops until every response is in, then resumes
   task automatic test_drain_pause();
      send_random_operand(8);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      send_random_operand(8);
      wait_idle();
   endtask

   // bulk random operands, starting with a stretch free of gaps and stalls
   task automatic test_random();
      int k, goal;
      goal = items_sent + RandomItems;
      no_idle = 1'b1;
      for (k = 0; k < 2; k++) send_random_operand(8);
      no_idle = 1'b0;
      while (items_sent < goal)
         send_random_operand(($urandom_range(0, 9) == 0) ? 30 : 8);
      wait_idle();
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_character = 8'h00;
      req_has_char  = 1'b0;
      req_mode      = ModeAsc;
      req_last      = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      mismatches    = 0;
      items_sent    = 0;
      hold_req      = 0;
      no_idle       = 1'b0;
      emit_on       = 1'b1;
      clear_operand();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_count_only();
      test_overflow();
      test_backpressure();
      test_drain_pause();
      test_random();

      // nothing pending; give a late stray response a chance to show
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
